// File: design/lscw_pkg.sv
// lscw_pkg: shared types, constants and character tables for the LCD segment character writer.
// Used by lscw_front, lscw_queue, lscw_back and lcd_segment_char_writer.
`timescale 1ns / 1ps

package lscw_pkg;

	localparam int FRAME_WORDS_DEF = 8;   // default frame store depth
	localparam int OUT_WORDS       = 8;   // words emitted per transaction
	localparam int QUEUE_DEPTH     = 2;   // command queue between front and back
	localparam int DIGITS          = 6;   // digit places on the glass

	localparam logic       OP_WRITE  = 1'b0;
	localparam logic       OP_CLEAR  = 1'b1;
	localparam logic [15:0] POINT_BIT = 16'h0002;
	localparam logic [15:0] COLON_BIT = 16'h0020;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_WRITE,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] code;
		logic [2:0]  pos;
	} cmd_t;

	localparam logic [15:0] CAP_TAB [26] = '{
		16'hFE00, 16'h6714, 16'h1D00, 16'h4714, 16'h9D00, 16'h9C00, 16'h3F00,
		16'hFA00, 16'h0014, 16'h5300, 16'h9841, 16'h1900, 16'h5A48, 16'h5A09,
		16'h5F00, 16'hFC00, 16'h5F01, 16'hFC01, 16'hAF00, 16'h0414, 16'h5B00,
		16'h18C0, 16'h5A81, 16'h00C9, 16'h0058, 16'h05C0
	};

	localparam logic [15:0] NUM_TAB [10] = '{
		16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEA00,
		16'hAF00, 16'hBF00, 16'h4600, 16'hFF00, 16'hEF00
	};

	// Byte to 16-bit segment code; unknown bytes are blank.
	function automatic logic [15:0] seg_code(input logic [7:0] c);
		logic [15:0] r;
		r = 16'h0000;
		case (c)
			8'h20: r = 16'h0000;
			8'h2A: r = 16'hA0DD;
			8'h28: r = 16'h0028;
			8'h29: r = 16'h0011;
			8'h64: r = 16'hF300;
			8'h6D: r = 16'hB210;
			8'h6E: r = 16'h2210;
			8'hB5: r = 16'h6084;
			8'h2D: r = 16'hA000;
			8'h2B: r = 16'hA014;
			8'h2F: r = 16'h00C0;
			8'hB0: r = 16'hEC00;
			8'h25: r = 16'hB300;
			8'hFF: r = 16'hFFDD;
			default: begin
				if (c >= 8'h30 && c <= 8'h39)
					r = NUM_TAB[4'(c - 8'h30)];
				else if (c >= 8'h41 && c <= 8'h5A)
					r = CAP_TAB[5'(c - 8'h41)];
				else if (c >= 8'h61 && c <= 8'h7A)
					r = CAP_TAB[5'(c - 8'h61)];
			end
		endcase
		return r;
	endfunction

	// Scatter map per digit place: entry b = {word offset, bit}, word offset in bit 5.
	function automatic logic [3:0][5:0] place_map(input logic [2:0] pos);
		logic [3:0][5:0] m;
		m = '0;
		case (pos)
			3'd0: m = {6'd3,  6'd22, 6'd23, 6'd4};
			3'd1: m = {6'd5,  6'd12, 6'd13, 6'd6};
			3'd2: m = {6'd14, 6'd28, 6'd29, 6'd15};
			3'd3: m = {6'd30, 6'd32, 6'd33, 6'd31};
			3'd4: m = {6'd34, 6'd24, 6'd25, 6'd35};
			3'd5: m = {6'd26, 6'd9,  6'd8,  6'd17};
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

// File: design/lscw_front.sv
// lscw_front: accepts input transactions, encodes the character and classifies the command.
// Depends on lscw_pkg; feeds lscw_queue.
`timescale 1ns / 1ps

module lscw_front (
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  logic                 operation,
	input  logic [7:0]           char_code,
	input  logic                 dp_lit,
	input  logic                 colon_lit,
	input  logic [2:0]           digit_position,
	input  logic                 q_full,
	output logic                 push,
	output lscw_pkg::cmd_t       push_cmd
);

	logic [15:0] code;

	assign cmd_ready = !q_full;
	assign push      = cmd_valid && cmd_ready;

	always_comb begin
		code = lscw_pkg::seg_code(char_code);
		if (dp_lit)
			code = code | lscw_pkg::POINT_BIT;
		if (colon_lit)
			code = code | lscw_pkg::COLON_BIT;
	end

	always_comb begin
		push_cmd.code = code;
		push_cmd.pos  = digit_position;
		if (operation == lscw_pkg::OP_CLEAR)
			push_cmd.kind = lscw_pkg::CMD_CLEAR;
		else if (32'(digit_position) < lscw_pkg::DIGITS)
			push_cmd.kind = lscw_pkg::CMD_WRITE;
		else
			push_cmd.kind = lscw_pkg::CMD_NOP;   // place six or seven: frame untouched
	end

endmodule

// File: design/lscw_queue.sv
// lscw_queue: short command FIFO between the front and back parts.
// Depends on lscw_pkg for the command type and depth.
`timescale 1ns / 1ps

module lscw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lscw_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output lscw_pkg::cmd_t pop_cmd,
	output logic           empty
);

	localparam int PTR_W = (lscw_pkg::QUEUE_DEPTH > 1) ? $clog2(lscw_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(lscw_pkg::QUEUE_DEPTH + 1);

	lscw_pkg::cmd_t    mem_q [lscw_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full    = (32'(count_q) == lscw_pkg::QUEUE_DEPTH);
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (32'(wr_ptr_q) == lscw_pkg::QUEUE_DEPTH - 1) ? '0
					: wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (32'(rd_ptr_q) == lscw_pkg::QUEUE_DEPTH - 1) ? '0
					: rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> !full) else $error("queue still full after pop");

endmodule

// File: design/lscw_back.sv
// lscw_back: frame store, command execution and word-by-word frame readout.
// Depends on lscw_pkg; takes commands from lscw_queue.
`timescale 1ns / 1ps

module lscw_back #(
	parameter int FRAME_WORDS = lscw_pkg::FRAME_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  lscw_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           word_valid,
	input  logic           word_ready,
	output logic [2:0]     word_index,
	output logic [31:0]    word_value,
	output logic           last_word
);

	localparam int IDX_W = $clog2(FRAME_WORDS);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t          state_q;
	logic [2:0]      cnt_q;
	logic [31:0]     frame_q [FRAME_WORDS];
	logic [31:0]     upd     [FRAME_WORDS];
	logic            load;
	logic            out_valid_q;
	logic [2:0]      out_index_q;
	logic [31:0]     out_value_q;
	logic            out_last_q;

	assign q_pop      = (state_q == ST_IDLE) && !q_empty;
	assign load       = (state_q == ST_EMIT) && (!out_valid_q || word_ready);
	assign word_valid = out_valid_q;
	assign word_index = out_index_q;
	assign word_value = out_value_q;
	assign last_word  = out_last_q;

	// Scatter the four code nibbles: nibble k goes to words 2k and 2k+1.
	always_comb begin
		logic [3:0][5:0] pm;
		logic [2:0]      w;
		pm = lscw_pkg::place_map(q_cmd.pos);
		for (int i = 0; i < FRAME_WORDS; i++)
			upd[i] = frame_q[i];
		for (int k = 0; k < 4; k++) begin
			for (int b = 0; b < 4; b++) begin
				w = 3'(2 * k) + {2'b00, pm[b][5]};
				upd[IDX_W'(w)][pm[b][4:0]] = q_cmd.code[12 - 4 * k + b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_index_q <= '0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
			for (int i = 0; i < FRAME_WORDS; i++)
				frame_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_cmd.kind)
							lscw_pkg::CMD_CLEAR: begin
								for (int i = 0; i < FRAME_WORDS; i++)
									frame_q[i] <= '0;
							end
							lscw_pkg::CMD_WRITE: begin
								for (int i = 0; i < FRAME_WORDS; i++)
									frame_q[i] <= upd[i];
							end
							default: ;
						endcase
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						out_index_q <= cnt_q;
						out_value_q <= frame_q[IDX_W'(cnt_q)];
						out_last_q  <= (32'(cnt_q) == lscw_pkg::OUT_WORDS - 1);
						cnt_q       <= cnt_q + 3'd1;
						if (32'(cnt_q) == lscw_pkg::OUT_WORDS - 1)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// output register drains when taken and nothing new is loaded
			if (out_valid_q && word_ready && !load)
				out_valid_q <= 1'b0;
		end
	end

	a_no_pop_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !q_pop) else $error("command taken during readout");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_cmd.kind == lscw_pkg::CMD_CLEAR |=> frame_q[0] == '0 && frame_q[7] == '0)
		else $error("frame not cleared");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && word_ready && !out_last_q
		|=> out_valid_q && out_index_q == $past(out_index_q) + 3'd1)
		else $error("readout word sequence broken");

endmodule

// File: design/lcd_segment_char_writer.sv
// lcd_segment_char_writer: top level of the six-digit 14-segment LCD character writer.
// Depends on lscw_pkg, lscw_front, lscw_queue and lscw_back.
`timescale 1ns / 1ps

// Channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------------
// command  | cmd_valid / cmd_ready  | operation, char_code, dp_lit, colon_lit,
//          |                        | digit_position
// word     | word_valid / word_ready| word_index, word_value, last_word
//
// Each command transaction yields eight word transactions, frame words 0..7 in order,
// last_word set on word 7. In the back part a command is first applied to the frame
// store, then the frame is read out through the single output register, and no new
// command is taken from the queue until that readout ends.
// Reset clears the frame store, queue and output register at once; no clearing pass.
// cmd_ready drops only when the two-entry command queue is full; word_ready low just
// freezes the readout, the front keeps taking commands until the queue fills.

module lcd_segment_char_writer #(
	parameter int FRAME_WORDS = lscw_pkg::FRAME_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic        operation,
	input  logic [7:0]  char_code,
	input  logic        dp_lit,
	input  logic        colon_lit,
	input  logic [2:0]  digit_position,
	output logic        word_valid,
	input  logic        word_ready,
	output logic [2:0]  word_index,
	output logic [31:0] word_value,
	output logic        last_word
);

	// front -> queue
	logic           push;
	lscw_pkg::cmd_t push_cmd;
	logic           q_full;
	// queue -> back
	logic           q_pop;
	lscw_pkg::cmd_t q_cmd;
	logic           q_empty;

	// Front: encodes the byte (points and colon ORed in) and tags write, clear or no-op.
	lscw_front u_front (
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.operation      (operation),
		.char_code      (char_code),
		.dp_lit         (dp_lit),
		.colon_lit      (colon_lit),
		.digit_position (digit_position),
		.q_full         (q_full),
		.push           (push),
		.push_cmd       (push_cmd)
	);

	// Decouples accept from readout so either side can stall alone.
	lscw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (q_cmd),
		.empty    (q_empty)
	);

	// Back: owns the frame store, applies one command, then streams the frame out.
	lscw_back #(
		.FRAME_WORDS (FRAME_WORDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word_index (word_index),
		.word_value (word_value),
		.last_word  (last_word)
	);

endmodule
